>>> design/trial_division_prime_test_assert.svh
// Assertion macros shared by the trial division prime test RTL
`ifndef TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH
`define TRIAL_DIVISION_PRIME_TEST_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define TDP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdp assertion failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define TDP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdp assertion failed");

`endif

>>> design/tdp_pkg.sv
// Package: widths, sequencer states and divider control types
`default_nettype none
package tdp_pkg;

    // Width of the candidate field on the port
    localparam int CAND_WIDTH  = 32;
    // Datapath width; the candidate is taken modulo 2^VALUE_WIDTH (range 4..64)
    localparam int VALUE_WIDTH = 32;
    // Bit step counter of the divider
    localparam int STEP_CNT_W  = $clog2(VALUE_WIDTH);

    // Sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_WAIT,
        ST_WRITE
    } tdp_state_t;

    // Divide request from the sequencer
    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] dividend;
        logic [VALUE_WIDTH-1:0] divisor;
    } tdp_div_req_t;

    // Divide response back to the sequencer
    typedef struct packed {
        logic                   busy;
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [VALUE_WIDTH-1:0] remainder;
    } tdp_div_rsp_t;

endpackage
`default_nettype wire

>>> design/tdp_if.sv
// Valid/ready channel interfaces for candidate and result beats
`default_nettype none

interface tdp_cand_if
    import tdp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CAND_WIDTH-1:0] candidate;

    modport source (output valid, output candidate, input ready);
    modport sink   (input valid, input candidate, output ready);
endinterface

interface tdp_result_if;
    logic valid;
    logic ready;
    logic is_prime;

    modport source (output valid, output is_prime, input ready);
    modport sink   (input valid, input is_prime, output ready);
endinterface

`default_nettype wire

>>> design/tdp_div.sv
// Bit-serial restoring divider: one quotient bit per cycle
`default_nettype none
`include "trial_division_prime_test_assert.svh"

module tdp_div
    import tdp_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire tdp_div_req_t req,
    output tdp_div_rsp_t      rsp
);

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [STEP_CNT_W-1:0]  step_reg, step_next;
    logic [VALUE_WIDTH-1:0] rem_reg, rem_next;
    logic [VALUE_WIDTH-1:0] quo_reg, quo_next;
    logic [VALUE_WIDTH-1:0] div_reg, div_next;

    logic [VALUE_WIDTH:0]   shifted;
    logic [VALUE_WIDTH:0]   trial;
    logic                   last_step;

    // One restoring step: shift in next dividend bit, try subtract
    assign shifted   = {rem_reg, quo_reg[VALUE_WIDTH-1]};
    assign trial     = shifted - {1'b0, div_reg};
    assign last_step = (step_reg == STEP_CNT_W'(VALUE_WIDTH - 1));

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        div_next  = div_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            step_next = '0;
            rem_next  = '0;
            quo_next  = req.dividend;
            div_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            if (!trial[VALUE_WIDTH])
            begin
                rem_next = trial[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[VALUE_WIDTH-1:0];
                quo_next = {quo_reg[VALUE_WIDTH-2:0], 1'b0};
            end
            step_next = step_reg + STEP_CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        div_reg <= div_next;
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;

    // Checks
    `TDP_ASSERT_NOW(a_start_when_free, req.start, !busy_reg && !done_reg)
    `TDP_ASSERT_NEXT(a_start_sets_busy, req.start, busy_reg && step_reg == '0)
    `TDP_ASSERT_NEXT(a_done_after_last, busy_reg && last_step && !req.start, done_reg && !busy_reg)

endmodule
`default_nettype wire

>>> design/trial_division_prime_test.sv
// Candidates below 4 or even skip the divider: the sequencer goes from ST_IDLE to ST_WRITE.
// Odd candidates run one trial divisor at a time through the bit-serial divider
// (ST_START, ST_WAIT) until a divisor divides n or d*d exceeds n.
// One candidate at a time; the next input beat is taken once the result sits in
// the output register, while that result still waits to be taken.
// Reset (rst_n, async, active low) clears the sequencer, output valid and divider control state only.
`default_nettype none
`include "trial_division_prime_test_assert.svh"

module trial_division_prime_test
    import tdp_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    tdp_cand_if.sink     request,
    tdp_result_if.source response
);

    tdp_state_t             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] n_reg, n_next;
    logic [VALUE_WIDTH-1:0] d_reg, d_next;
    logic                   prime_reg, prime_next;
    logic                   out_valid_reg, out_valid_next;
    logic                   out_prime_reg, out_prime_next;

    logic [VALUE_WIDTH-1:0] cand_v;
    logic                   in_beat;
    logic                   out_free;
    logic                   cand_trivial;
    logic                   past_bound;
    tdp_div_req_t           div_req;
    tdp_div_rsp_t           div_rsp;

    assign cand_v       = VALUE_WIDTH'(request.candidate);
    assign in_beat      = request.valid && request.ready;
    assign out_free     = !out_valid_reg || response.ready;
    // Below 4 or even: answered without any division
    assign cand_trivial = (cand_v < VALUE_WIDTH'(4)) || !cand_v[0];
    // d*d > n exactly when d > n/d
    assign past_bound   = d_reg > div_rsp.quotient;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (request.valid)
                    state_next = cand_trivial ? ST_WRITE : ST_START;
            end
            ST_START:
                state_next = ST_WAIT;
            ST_WAIT:
            begin
                if (div_rsp.done)
                begin
                    if (past_bound || div_rsp.remainder == '0)
                        state_next = ST_WRITE;
                    else
                        state_next = ST_START;
                end
            end
            ST_WRITE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        request.ready    = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = n_reg;
        div_req.divisor  = d_reg;
        unique case (state_reg)
            ST_IDLE:  request.ready = 1'b1;
            ST_START: div_req.start = 1'b1;
            ST_WAIT,
            ST_WRITE: ;
            default:  ;
        endcase
    end

    // Datapath registers
    always_comb
    begin
        n_next         = n_reg;
        d_next         = d_reg;
        prime_next     = prime_reg;
        out_prime_next = out_prime_reg;
        out_valid_next = out_valid_reg && !response.ready;
        if (in_beat)
        begin
            n_next     = cand_v;
            d_next     = VALUE_WIDTH'(3);
            // 2 and 3 prime, 0, 1 and other evens not
            prime_next = (cand_v < VALUE_WIDTH'(4)) ? (cand_v > VALUE_WIDTH'(1)) : 1'b0;
        end
        if (state_reg == ST_WAIT && div_rsp.done)
        begin
            prime_next = past_bound;
            d_next     = d_reg + VALUE_WIDTH'(2);
        end
        if (state_reg == ST_WRITE && out_free)
        begin
            out_valid_next = 1'b1;
            out_prime_next = prime_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg         <= n_next;
        d_reg         <= d_next;
        prime_reg     <= prime_next;
        out_prime_reg <= out_prime_next;
    end

    assign response.valid    = out_valid_reg;
    assign response.is_prime = out_prime_reg;

    tdp_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Checks
    `TDP_ASSERT_NOW(a_idle_div_free, request.ready, !div_rsp.busy && !div_rsp.done)
    `TDP_ASSERT_NOW(a_odd_divisor, div_req.start, d_reg[0] && d_reg > VALUE_WIDTH'(1))
    `TDP_ASSERT_NOW(a_done_in_wait, div_rsp.done, state_reg == ST_WAIT)
    `TDP_ASSERT_NEXT(a_even_not_prime, in_beat && !cand_v[0] && cand_v > VALUE_WIDTH'(2), state_reg == ST_WRITE && !prime_reg)

endmodule
`default_nettype wire
